// ===== design/assert_macros.svh =====
// Assertion macros used by the time-of-day adder unit.
// Each macro assumes a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a trigger implies a consequence in the same cycle
`define ASSERT_IMPLY(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed");

// Check that a trigger implies a consequence in the next cycle
`define ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/rtcad_pkg.sv =====
// Shared constants and types for the time-of-day adder.
// No dependencies; used by the flow control and the top level.
`timescale 1ns / 1ps

package rtcad_pkg;

  // Pipeline depth: the output register is the last stage
  localparam int NumStages = 10;

  // Field widths
  localparam int SubW   = 7;
  localparam int SecW   = 6;
  localparam int MinW   = 6;
  localparam int HourW  = 5;
  localparam int DeltaW = 32;
  localparam int InDataW  = 56;
  localparam int OutDataW = 24;

  // Whole seconds in the interval: delta with the tick bits dropped
  localparam int WholeSecW = DeltaW - SubW;

  // Time units
  localparam logic [7:0] SecondsPerMinute = 8'd60;
  localparam logic [7:0] MinutesPerHour   = 8'd60;
  localparam logic [7:0] HoursPerDay      = 8'd24;

  // Reciprocals for division by 60 and by 24; estimate is exact or one low
  localparam logic [20:0] RecipDiv60 = 21'd1118481;
  localparam logic [15:0] RecipDiv24 = 16'd43690;

  // Per-stage advance enables and valid bits
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } rtcad_pipe_t;

endpackage

// ===== design/rtc_time_of_day_adder_unit.sv =====
// Time-of-day adder: adds an interval in 1/128 s ticks to a time of day.
// Each word passes through every pipeline stage in order; the last stage is the output register.
// Throughput: one word per cycle while the output is not stalled; the reciprocal multipliers are pipelined.
// A stalled output holds only the stages behind it; bubbles are filled.
// Reset (synchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtc_time_of_day_adder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_subsecond[6:0], start_second[12:7], start_minute[18:13],
  // start_hour[23:19], delta_ticks[55:24]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // end_subsecond[6:0], end_second[12:7], end_minute[18:13], end_hour[23:19]
  output logic [23:0] m_tdata
);

  localparam int N = rtcad_pkg::NumStages;

  rtcad_pkg::rtcad_pipe_t pipe;

  rtcad_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .pipe      (pipe)
  );

  assign s_tready = pipe.en[0];
  assign m_tvalid = pipe.vld[N-1];

  // Unpack the input word
  logic [rtcad_pkg::SubW-1:0]      in_sub;
  logic [rtcad_pkg::SecW-1:0]      in_sec;
  logic [rtcad_pkg::MinW-1:0]      in_min;
  logic [rtcad_pkg::HourW-1:0]     in_hour;
  logic [rtcad_pkg::DeltaW-1:0]    in_delta;
  logic [rtcad_pkg::WholeSecW-1:0] in_wsec;
  logic [rtcad_pkg::SubW:0]        in_tick_sum;

  assign in_sub      = s_tdata[6:0];
  assign in_sec      = s_tdata[12:7];
  assign in_min      = s_tdata[18:13];
  assign in_hour     = s_tdata[23:19];
  assign in_delta    = s_tdata[55:24];
  assign in_wsec     = in_delta[rtcad_pkg::DeltaW-1:rtcad_pkg::SubW];
  assign in_tick_sum = {1'b0, in_sub} + {1'b0, in_delta[rtcad_pkg::SubW-1:0]};

  // Stage 1: add ticks, start whole seconds / 60
  logic [24:0] s1_x;
  logic [45:0] s1_prod;
  logic [6:0]  s1_tick;
  logic        s1_cs;
  logic [5:0]  s1_sec0;
  logic [5:0]  s1_min0;
  logic [4:0]  s1_hr0;

  always_ff @(posedge clk) begin
    if (pipe.en[0]) begin
      s1_x    <= in_wsec;
      s1_prod <= in_wsec * rtcad_pkg::RecipDiv60;
      s1_tick <= in_tick_sum[6:0];
      s1_cs   <= in_tick_sum[7];
      s1_sec0 <= in_sec;
      s1_min0 <= in_min;
      s1_hr0  <= in_hour;
    end
  end

  // Stage 2: quotient estimate and remainder for seconds
  logic [19:0] s2_q;
  logic [6:0]  s2_r;
  logic [6:0]  s2_tick;
  logic        s2_cs;
  logic [5:0]  s2_sec0;
  logic [5:0]  s2_min0;
  logic [4:0]  s2_hr0;
  logic [19:0] q1_est;
  logic [24:0] r1_full;

  assign q1_est  = s1_prod[45:26];
  assign r1_full = s1_x - ({5'd0, q1_est} * 25'(rtcad_pkg::SecondsPerMinute));

  always_ff @(posedge clk) begin
    if (pipe.en[1]) begin
      s2_q    <= q1_est;
      s2_r    <= r1_full[6:0];
      s2_tick <= s1_tick;
      s2_cs   <= s1_cs;
      s2_sec0 <= s1_sec0;
      s2_min0 <= s1_min0;
      s2_hr0  <= s1_hr0;
    end
  end

  // Stage 3: correct the estimate, sum seconds
  logic [19:0] s3_wm;
  logic [6:0]  s3_ssum;
  logic [6:0]  s3_tick;
  logic [5:0]  s3_min0;
  logic [4:0]  s3_hr0;
  logic        r1_over;
  logic [6:0]  d_sec;

  assign r1_over = s2_r >= 7'(rtcad_pkg::SecondsPerMinute);
  assign d_sec   = r1_over ? s2_r - 7'(rtcad_pkg::SecondsPerMinute) : s2_r;

  always_ff @(posedge clk) begin
    if (pipe.en[2]) begin
      s3_wm   <= s2_q + {19'd0, r1_over};
      s3_ssum <= {1'b0, s2_sec0} + d_sec + {6'd0, s2_cs};
      s3_tick <= s2_tick;
      s3_min0 <= s2_min0;
      s3_hr0  <= s2_hr0;
    end
  end

  // Stage 4: normalise seconds, start whole minutes / 60
  logic [40:0] s4_prod;
  logic [19:0] s4_wm;
  logic [5:0]  s4_sec;
  logic [1:0]  s4_cm;
  logic [6:0]  s4_tick;
  logic [5:0]  s4_min0;
  logic [4:0]  s4_hr0;
  logic [1:0]  sec_carry;
  logic [6:0]  sec_norm;

  always_comb begin
    priority if (s3_ssum >= 7'(2 * rtcad_pkg::SecondsPerMinute)) begin
      sec_carry = 2'd2;
      sec_norm  = s3_ssum - 7'(2 * rtcad_pkg::SecondsPerMinute);
    end else if (s3_ssum >= 7'(rtcad_pkg::SecondsPerMinute)) begin
      sec_carry = 2'd1;
      sec_norm  = s3_ssum - 7'(rtcad_pkg::SecondsPerMinute);
    end else begin
      sec_carry = 2'd0;
      sec_norm  = s3_ssum;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en[3]) begin
      s4_prod <= s3_wm * rtcad_pkg::RecipDiv60;
      s4_wm   <= s3_wm;
      s4_sec  <= sec_norm[5:0];
      s4_cm   <= sec_carry;
      s4_tick <= s3_tick;
      s4_min0 <= s3_min0;
      s4_hr0  <= s3_hr0;
    end
  end

  // Stage 5: quotient estimate and remainder for minutes
  logic [13:0] s5_q;
  logic [6:0]  s5_r;
  logic [5:0]  s5_sec;
  logic [1:0]  s5_cm;
  logic [6:0]  s5_tick;
  logic [5:0]  s5_min0;
  logic [4:0]  s5_hr0;
  logic [13:0] q2_est;
  logic [19:0] r2_full;

  assign q2_est  = s4_prod[39:26];
  assign r2_full = s4_wm - ({6'd0, q2_est} * 20'(rtcad_pkg::MinutesPerHour));

  always_ff @(posedge clk) begin
    if (pipe.en[4]) begin
      s5_q    <= q2_est;
      s5_r    <= r2_full[6:0];
      s5_sec  <= s4_sec;
      s5_cm   <= s4_cm;
      s5_tick <= s4_tick;
      s5_min0 <= s4_min0;
      s5_hr0  <= s4_hr0;
    end
  end

  // Stage 6: correct the estimate, sum minutes
  logic [13:0] s6_dhr;
  logic [6:0]  s6_msum;
  logic [5:0]  s6_sec;
  logic [6:0]  s6_tick;
  logic [4:0]  s6_hr0;
  logic        r2_over;
  logic [6:0]  d_min;

  assign r2_over = s5_r >= 7'(rtcad_pkg::MinutesPerHour);
  assign d_min   = r2_over ? s5_r - 7'(rtcad_pkg::MinutesPerHour) : s5_r;

  always_ff @(posedge clk) begin
    if (pipe.en[5]) begin
      s6_dhr  <= s5_q + {13'd0, r2_over};
      s6_msum <= {1'b0, s5_min0} + d_min + {5'd0, s5_cm};
      s6_sec  <= s5_sec;
      s6_tick <= s5_tick;
      s6_hr0  <= s5_hr0;
    end
  end

  // Stage 7: normalise minutes, sum hours
  logic [13:0] s7_hsum;
  logic [5:0]  s7_min;
  logic [5:0]  s7_sec;
  logic [6:0]  s7_tick;
  logic [1:0]  min_carry;
  logic [6:0]  min_norm;

  always_comb begin
    priority if (s6_msum >= 7'(2 * rtcad_pkg::MinutesPerHour)) begin
      min_carry = 2'd2;
      min_norm  = s6_msum - 7'(2 * rtcad_pkg::MinutesPerHour);
    end else if (s6_msum >= 7'(rtcad_pkg::MinutesPerHour)) begin
      min_carry = 2'd1;
      min_norm  = s6_msum - 7'(rtcad_pkg::MinutesPerHour);
    end else begin
      min_carry = 2'd0;
      min_norm  = s6_msum;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en[6]) begin
      s7_hsum <= s6_dhr + {9'd0, s6_hr0} + {12'd0, min_carry};
      s7_min  <= min_norm[5:0];
      s7_sec  <= s6_sec;
      s7_tick <= s6_tick;
    end
  end

  // Stage 8: start hours / 24
  logic [29:0] s8_prod;
  logic [13:0] s8_hsum;
  logic [5:0]  s8_min;
  logic [5:0]  s8_sec;
  logic [6:0]  s8_tick;

  always_ff @(posedge clk) begin
    if (pipe.en[7]) begin
      s8_prod <= s7_hsum * rtcad_pkg::RecipDiv24;
      s8_hsum <= s7_hsum;
      s8_min  <= s7_min;
      s8_sec  <= s7_sec;
      s8_tick <= s7_tick;
    end
  end

  // Stage 9: remainder of hours against the estimate
  logic [5:0]  s9_r;
  logic [5:0]  s9_min;
  logic [5:0]  s9_sec;
  logic [6:0]  s9_tick;
  logic [9:0]  q3_est;
  logic [13:0] r3_full;

  assign q3_est  = s8_prod[29:20];
  assign r3_full = s8_hsum - ({4'd0, q3_est} * 14'(rtcad_pkg::HoursPerDay));

  always_ff @(posedge clk) begin
    if (pipe.en[8]) begin
      s9_r    <= r3_full[5:0];
      s9_min  <= s8_min;
      s9_sec  <= s8_sec;
      s9_tick <= s8_tick;
    end
  end

  // Stage 10: final hour correction into the output register
  logic [5:0] hr_norm;

  assign hr_norm = (s9_r >= 6'(rtcad_pkg::HoursPerDay)) ?
                   s9_r - 6'(rtcad_pkg::HoursPerDay) : s9_r;

  always_ff @(posedge clk) begin
    if (pipe.en[9]) begin
      m_tdata <= {hr_norm[4:0], s9_min, s9_sec, s9_tick};
    end
  end

  // Reciprocal estimates are never more than one low
  `ASSERT_IMPLY(a_sec_rem, pipe.vld[1], s2_r < 7'(2 * rtcad_pkg::SecondsPerMinute))
  `ASSERT_IMPLY(a_hour_rem, pipe.vld[8], s9_r < 6'(2 * rtcad_pkg::HoursPerDay))
  // Output fields always in range
  `ASSERT_IMPLY(a_out_range, m_tvalid,
                (m_tdata[12:7] < 6'd60) && (m_tdata[18:13] < 6'd60) &&
                (m_tdata[23:19] < 5'd24))
  // A full pipe with a stalled output takes no word
  `ASSERT_IMPLY(a_full_stall, (pipe.vld == '1) && !m_tready, !s_tready)

endmodule

// ===== design/rtcad_flow.sv =====
// Flow control for the time-of-day adder pipeline: valid bits and stage enables.
// Depends on rtcad_pkg for the stage count and the control struct.
`timescale 1ns / 1ps

module rtcad_flow (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_ready,
  output rtcad_pkg::rtcad_pipe_t pipe
);

  logic [rtcad_pkg::NumStages-1:0] vld;
  logic [rtcad_pkg::NumStages-1:0] en;

  // Let a stage load when it is empty or its successor moves on
  always_comb begin
    en[rtcad_pkg::NumStages-1] = !vld[rtcad_pkg::NumStages-1] || out_ready;
    for (int i = rtcad_pkg::NumStages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // Advance valid bits with the data, collapsing bubbles
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < rtcad_pkg::NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign pipe.en  = en;
  assign pipe.vld = vld;

endmodule

// ===== tb/tb_rtc_time_of_day_adder_unit.sv =====
// Self-checking bench for rtc_time_of_day_adder_unit: a directed table, then random words.
// Depends on rtcad_pkg for field widths and pipeline depth, and on the adder itself.
`timescale 1ns / 1ps

module tb_rtc_time_of_day_adder_unit;

  localparam int unsigned TickHz      = 128;
  localparam int unsigned TickMask    = 32'h7f;
  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned HourPerDay  = 24;
  localparam int unsigned TicksPerDay = TickHz * SecPerMin * MinPerHour * HourPerDay;

  localparam int RandomWords   = 750;
  localparam int CalmFirst     = 250;
  localparam int CalmLast      = 450;
  localparam int HoldOffAfter  = 300;
  localparam int HoldOffCycles = 150;
  localparam int CycleLimit    = 200000;
  localparam int MaxReports    = 10;
  localparam int DirectedCount = 15;

  // Input word: start time of day plus the interval, start subsecond in the low bits
  typedef struct packed {
    logic [rtcad_pkg::DeltaW-1:0] delta_ticks;
    logic [rtcad_pkg::HourW-1:0]  start_hour;
    logic [rtcad_pkg::MinW-1:0]   start_minute;
    logic [rtcad_pkg::SecW-1:0]   start_second;
    logic [rtcad_pkg::SubW-1:0]   start_subsecond;
  } tod_request_t;

  // Output word: normalised end time
  typedef struct packed {
    logic [rtcad_pkg::HourW-1:0] end_hour;
    logic [rtcad_pkg::MinW-1:0]  end_minute;
    logic [rtcad_pkg::SecW-1:0]  end_second;
    logic [rtcad_pkg::SubW-1:0]  end_subsecond;
  } tod_end_t;

  typedef struct packed {
    tod_request_t req;
    logic         typed;
    tod_end_t     want;
  } tod_row_t;

  // Directed rows; where typed is clear the predictor supplies the end time
  localparam tod_row_t DirectedRows [DirectedCount] = '{
    // zero interval from midnight, straight after reset
    '{'{32'd0,        5'd0,  6'd0,  6'd0,  7'd0},   1'b1, '{5'd0,  6'd0,  6'd0,  7'd0}},
    // one tick ripples a carry through every field and wraps the hour
    '{'{32'd1,        5'd23, 6'd59, 6'd59, 7'd127}, 1'b1, '{5'd0,  6'd0,  6'd0,  7'd0}},
    // start fields beyond their range are taken at face value and normalised
    '{'{32'd0,        5'd31, 6'd63, 6'd63, 7'd127}, 1'b1, '{5'd8,  6'd4,  6'd3,  7'd127}},
    // one unit of each field
    '{'{32'd128,      5'd0,  6'd0,  6'd0,  7'd0},   1'b1, '{5'd0,  6'd0,  6'd1,  7'd0}},
    '{'{32'd7680,     5'd0,  6'd0,  6'd0,  7'd0},   1'b1, '{5'd0,  6'd1,  6'd0,  7'd0}},
    '{'{32'd460800,   5'd0,  6'd0,  6'd0,  7'd0},   1'b1, '{5'd1,  6'd0,  6'd0,  7'd0}},
    // hour wrap leaves the minute alone
    '{'{32'd460800,   5'd23, 6'd59, 6'd0,  7'd0},   1'b1, '{5'd0,  6'd59, 6'd0,  7'd0}},
    // a whole day is dropped without trace
    '{'{32'd11059200, 5'd5,  6'd6,  6'd7,  7'd8},   1'b1, '{5'd5,  6'd6,  6'd7,  7'd8}},
    // tick carry into the second
    '{'{32'd127,      5'd12, 6'd30, 6'd30, 7'd1},   1'b1, '{5'd12, 6'd30, 6'd31, 7'd0}},
    // largest interval, from zero and from all-ones fields
    '{'{32'hffffffff, 5'd0,  6'd0,  6'd0,  7'd0},   1'b0, '0},
    '{'{32'hffffffff, 5'd31, 6'd63, 6'd63, 7'd127}, 1'b0, '0},
    // alternating bit patterns, then the top bit alone
    '{'{32'h55555555, 5'd10, 6'd21, 6'd42, 7'd85},  1'b0, '0},
    '{'{32'haaaaaaaa, 5'd21, 6'd42, 6'd21, 7'd42},  1'b0, '0},
    '{'{32'h80000000, 5'd0,  6'd0,  6'd0,  7'd0},   1'b0, '0},
    // tick and second carries together
    '{'{32'd7679,     5'd0,  6'd0,  6'd59, 7'd1},   1'b0, '0}
  };

  logic                          clk;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [rtcad_pkg::InDataW-1:0]  s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [rtcad_pkg::OutDataW-1:0] m_tdata;

  tod_end_t expected_end_times [$];
  tod_end_t seen_end;
  tod_end_t wanted_end;
  bit       calm            = 1'b0;
  int       words_accepted  = 0;
  int       results_checked = 0;
  int       mismatch_count  = 0;
  int       cycle_count     = 0;

  rtc_time_of_day_adder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Free-running clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Split the interval into fields, add them and ripple the carries upward
  function automatic tod_end_t add_interval_to_time(tod_request_t r);
    int unsigned whole_s;
    int unsigned whole_m;
    int unsigned d_sec;
    int unsigned d_min;
    int unsigned d_hr;
    int unsigned tick;
    int unsigned sec;
    int unsigned mins;
    int unsigned hr;
    tod_end_t    e;
    whole_s = r.delta_ticks / TickHz;
    d_sec   = whole_s % SecPerMin;
    whole_m = whole_s / SecPerMin;
    d_min   = whole_m % MinPerHour;
    d_hr    = whole_m / MinPerHour;
    tick    = r.start_subsecond + (r.delta_ticks & TickMask);
    sec     = r.start_second + d_sec + tick / TickHz;
    tick    = tick % TickHz;
    mins    = r.start_minute + d_min + sec / SecPerMin;
    sec     = sec % SecPerMin;
    hr      = r.start_hour + d_hr + mins / MinPerHour;
    mins    = mins % MinPerHour;
    hr      = hr % HourPerDay;
    e.end_subsecond = 7'(tick);
    e.end_second    = 6'(sec);
    e.end_minute    = 6'(mins);
    e.end_hour      = 5'(hr);
    return e;
  endfunction

  // Mostly valid times of day with assorted intervals, some raw noise words
  function automatic tod_request_t make_random_request();
    tod_request_t r;
    int unsigned  pick;
    int unsigned  unit;
    logic [63:0]  raw;
    pick = $urandom_range(0, 99);
    r.start_subsecond = 7'($urandom_range(0, TickHz - 1));
    r.start_second    = 6'($urandom_range(0, SecPerMin - 1));
    r.start_minute    = 6'($urandom_range(0, MinPerHour - 1));
    r.start_hour      = 5'($urandom_range(0, HourPerDay - 1));
    if (pick < 30) begin
      r.delta_ticks = $urandom;
    end else if (pick < 60) begin
      r.delta_ticks = $urandom_range(0, TicksPerDay - 1);
    end else if (pick < 75) begin
      // sit on the rollover edges so short intervals carry through every field
      if ($urandom_range(0, 1)) r.start_subsecond = 7'(TickHz - 1);
      if ($urandom_range(0, 1)) r.start_second = 6'(SecPerMin - 1);
      if ($urandom_range(0, 1)) r.start_minute = 6'(MinPerHour - 1);
      if ($urandom_range(0, 1)) r.start_hour = 5'(HourPerDay - 1);
      r.delta_ticks = $urandom_range(0, 300);
    end else if (pick < 90) begin
      // whole units, one tick either side
      case ($urandom_range(0, 3))
        0: unit = TickHz;
        1: unit = TickHz * SecPerMin;
        2: unit = TickHz * SecPerMin * MinPerHour;
        default: unit = TicksPerDay;
      endcase
      r.delta_ticks = unit * $urandom_range(0, 100) + $urandom_range(0, 2) - 1;
    end else begin
      raw = {$urandom, $urandom};
      r = raw[rtcad_pkg::InDataW-1:0];
    end
    return r;
  endfunction

  // Offer one word, wait for its acceptance, then record what must come out
  task automatic offer_word(input tod_request_t req, input tod_end_t want);
    if (!calm && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_end_times.push_back(want);
    words_accepted++;
  endtask

  // Stimulus: reset, directed table, random words, drain, verdict
  initial begin
    tod_row_t     row;
    tod_request_t req;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      offer_word(row.req, row.typed ? row.want : add_interval_to_time(row.req));
    end
    for (int n = 0; n < RandomWords; n++) begin
      calm = (n >= CalmFirst && n < CalmLast);
      req  = make_random_request();
      offer_word(req, add_interval_to_time(req));
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;
    while (expected_end_times.size() != 0) @(posedge clk);
    repeat (4 * rtcad_pkg::NumStages) @(posedge clk);
    $display("Run covered %0d directed rows and %0d random words; %0d end times checked,",
             DirectedCount, RandomWords, results_checked);
    $display("including carries, hour wraps, day overflow and a long output stall; %0d failures",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Output side: random back-pressure, a calm stretch, and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_accepted >= HoldOffAfter) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles - 1;
        m_tready <= 1'b0;
      end else if (calm || rst) begin
        m_tready <= !rst;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Compare each accepted end time with the oldest one outstanding
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_end = m_tdata;
      if (expected_end_times.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("Unexpected result word %h:%h:%h.%h at cycle %0d", seen_end.end_hour,
                   seen_end.end_minute, seen_end.end_second, seen_end.end_subsecond,
                   cycle_count);
      end else begin
        wanted_end = expected_end_times.pop_front();
        results_checked++;
        if (seen_end.end_subsecond !== wanted_end.end_subsecond ||
            seen_end.end_second !== wanted_end.end_second ||
            seen_end.end_minute !== wanted_end.end_minute ||
            seen_end.end_hour !== wanted_end.end_hour) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("Result %0d: expected %0d:%0d:%0d.%0d, got %0d:%0d:%0d.%0d",
                     results_checked, wanted_end.end_hour, wanted_end.end_minute,
                     wanted_end.end_second, wanted_end.end_subsecond, seen_end.end_hour,
                     seen_end.end_minute, seen_end.end_second, seen_end.end_subsecond);
        end
      end
    end
  end

  // Watchdog: end the run if the pipeline never drains
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d end times outstanding", cycle_count,
             expected_end_times.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
